>>> rtl/core/aimcw_pkg.sv
// Types, constants and helpers shared by the ARP IP/MAC conflict watch.
// No dependencies.
package aimcw_pkg;

	localparam int IP_ENTRIES  = 64;
	localparam int MACS_PER_IP = 8;
	localparam int IP_W  = (IP_ENTRIES > 1) ? $clog2(IP_ENTRIES) : 1;
	localparam int MAC_W = $clog2(MACS_PER_IP);
	localparam int CNT_W = $clog2(MACS_PER_IP + 1);

	localparam logic [15:0] WINDOW_RESET  = 16'd300;
	localparam logic [15:0] MIN_ARP_FRAME = 16'd42;
	localparam logic [15:0] ETYPE_ARP     = 16'h0806;

	typedef enum logic [1:0] {
		ST_IGNORED = 2'd0,
		ST_INFO    = 2'd1,
		ST_ALERT   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		EM_NONE   = 3'd0,
		EM_IGNORE = 3'd1,
		EM_FULL   = 3'd2,
		EM_INFO   = 3'd3,
		EM_ALERT  = 3'd4
	} emit_t;

	typedef struct packed {
		logic [15:0] frame_length;
		logic [15:0] eth_proto;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [31:0] now_seconds;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] ip_echo;
		logic [47:0] listed_mac;
		logic [3:0]  mac_count;
		logic        mac_replaced;
		logic        last;
	} res_t;

	typedef struct packed {
		logic             v;
		logic [47:0]      addr;
		logic [31:0]      stamp;
		logic [MAC_W-1:0] rank;
	} slot_t;

	typedef slot_t [MACS_PER_IP-1:0] row_t;

	typedef struct packed {
		logic  capture;
		logic  scan_rd;
		logic  decide;
		logic  row_rd;
		logic  expire;
		logic  rerank;
		logic  update;
		logic  write_back;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic arp;
		logic scan_last;
		logic full;
		logic single;
		logic run_last;
	} st_t;

	// modular age test: strictly older than the window
	function automatic logic is_stale(logic [31:0] stamp, logic [31:0] now,
			logic [15:0] win);
		logic [31:0] age;
		age = now - stamp;
		return age > {16'd0, win};
	endfunction

endpackage

>>> rtl/core/aimcw_ctrl.sv
// Sequencer for the conflict watch: steps the datapath through scan,
// record update and result emission. Depends on aimcw_pkg.
module aimcw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  aimcw_pkg::st_t  st,
	output aimcw_pkg::cmd_t cmd,
	output logic            busy
);
	import aimcw_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_SCAN     = 11'b00000000010,
		S_SCAN_END = 11'b00000000100,
		S_DECIDE   = 11'b00000001000,
		S_ROW_RD   = 11'b00000010000,
		S_EXPIRE   = 11'b00000100000,
		S_RERANK   = 11'b00001000000,
		S_UPDATE   = 11'b00010000000,
		S_WRITE    = 11'b00100000000,
		S_EMIT     = 11'b01000000000,
		S_SPARE    = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.emit = EM_NONE;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (st.arp) begin
						cmd.capture = 1'b1;
						state_d     = S_SCAN;
					end else begin
						cmd.emit = EM_IGNORE;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (st.scan_last) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: state_d = S_DECIDE;
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (st.full) begin
					cmd.emit = EM_FULL;
					state_d  = S_IDLE;
				end else begin
					state_d = S_ROW_RD;
				end
			end
			S_ROW_RD: begin
				cmd.row_rd = 1'b1;
				state_d    = S_EXPIRE;
			end
			S_EXPIRE: begin
				cmd.expire = 1'b1;
				state_d    = S_RERANK;
			end
			S_RERANK: begin
				cmd.rerank = 1'b1;
				state_d    = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_WRITE;
			end
			S_WRITE: begin
				cmd.write_back = 1'b1;
				if (st.single) begin
					cmd.emit = EM_INFO;
					state_d  = S_IDLE;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit = EM_ALERT;
				if (st.run_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> rtl/core/aimcw_dp.sv
// Datapath: IP table, per-record MAC rows, record update and result register.
// Depends on aimcw_pkg.
module aimcw_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  aimcw_pkg::item_t item,
	input  logic            window_we,
	input  logic [15:0]     window_data,
	input  aimcw_pkg::cmd_t cmd,
	output aimcw_pkg::st_t  st,
	output aimcw_pkg::res_t result,
	output logic            result_strobe
);
	import aimcw_pkg::*;

	logic [15:0]           win_q;
	logic [31:0]           ip_q, now_q;
	logic [47:0]           mac_q;
	logic [IP_ENTRIES-1:0] ip_valid_q;
	logic [31:0]           ip_mem [IP_ENTRIES];
	row_t                  row_mem [IP_ENTRIES];
	logic [31:0]           ip_rd_q;
	row_t                  row_rd_q;
	logic [IP_W-1:0]       scan_cnt_q, eval_idx_s1, rec_q;
	logic [IP_W-1:0]       match_idx_q, inval_idx_q, stale_idx_q, dec_rec;
	logic                  eval_s1, match_q, inval_q, stale_q, new_q;
	row_t                  work_q, ex_row, rr_row, up_row;
	logic                  hit_q, rr_hit, up_repl;
	logic [MAC_W-1:0]      hit_idx_q, rr_hit_idx;
	logic [CNT_W-1:0]      cnt_q, rr_cnt, up_cnt, emit_r_q;
	logic                  repl_q, row_all_stale, ip_wr, up_full, free_found;
	logic [IP_W-1:0]       rd_addr;
	logic [47:0]           sel_mac;
	res_t                  res_q;
	logic                  strobe_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WINDOW_RESET;
		end else if (window_we) begin
			win_q <= window_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ip_q  <= item.sender_ip;
			mac_q <= item.sender_mac;
			now_q <= item.now_seconds;
		end
	end

	// memories: one read port shared by scan and record fetch
	assign rd_addr = cmd.scan_rd ? scan_cnt_q : rec_q;
	assign ip_wr   = cmd.decide && !match_q && (inval_q || stale_q);
	assign dec_rec = match_q ? match_idx_q : (inval_q ? inval_idx_q : stale_idx_q);

	always_ff @(posedge clk) begin
		if (cmd.scan_rd || cmd.row_rd) begin
			ip_rd_q  <= ip_mem[rd_addr];
			row_rd_q <= row_mem[rd_addr];
		end
		if (ip_wr) begin
			ip_mem[dec_rec] <= ip_q;
		end
		if (cmd.write_back) begin
			row_mem[rec_q] <= work_q;
		end
	end

	always_comb begin
		row_all_stale = 1'b1;
		for (int k = 0; k < MACS_PER_IP; k++) begin
			if (row_rd_q[k].v && !is_stale(row_rd_q[k].stamp, now_q, win_q)) begin
				row_all_stale = 1'b0;
			end
		end
	end

	// table scan, first hit of each kind kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			eval_s1    <= 1'b0;
			match_q    <= 1'b0;
			inval_q    <= 1'b0;
			stale_q    <= 1'b0;
			new_q      <= 1'b0;
			ip_valid_q <= '0;
		end else begin
			eval_s1 <= cmd.scan_rd;
			if (cmd.capture) begin
				scan_cnt_q <= '0;
				match_q    <= 1'b0;
				inval_q    <= 1'b0;
				stale_q    <= 1'b0;
			end else if (cmd.scan_rd) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (eval_s1) begin
				if (!match_q && ip_valid_q[eval_idx_s1] && ip_rd_q == ip_q) begin
					match_q <= 1'b1;
				end
				if (!inval_q && !ip_valid_q[eval_idx_s1]) begin
					inval_q <= 1'b1;
				end
				if (!stale_q && ip_valid_q[eval_idx_s1] && row_all_stale) begin
					stale_q <= 1'b1;
				end
			end
			if (cmd.decide) begin
				new_q <= !match_q;
			end
			if (ip_wr) begin
				ip_valid_q[dec_rec] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		eval_idx_s1 <= scan_cnt_q;
		if (eval_s1) begin
			if (!match_q) match_idx_q <= eval_idx_s1;
			if (!inval_q) inval_idx_q <= eval_idx_s1;
			if (!stale_q) stale_idx_q <= eval_idx_s1;
		end
		if (cmd.decide) begin
			rec_q <= dec_rec;
		end
	end

	// expiry: a fresh record starts empty
	always_comb begin
		ex_row = row_rd_q;
		for (int k = 0; k < MACS_PER_IP; k++) begin
			ex_row[k].v = !new_q && row_rd_q[k].v
				&& !is_stale(row_rd_q[k].stamp, now_q, win_q);
		end
	end

	// compact ranks over survivors, find sender MAC
	always_comb begin
		rr_row     = work_q;
		rr_hit     = 1'b0;
		rr_hit_idx = '0;
		rr_cnt     = '0;
		for (int k = 0; k < MACS_PER_IP; k++) begin
			rr_row[k].rank = '0;
			for (int j = 0; j < MACS_PER_IP; j++) begin
				if (work_q[j].v && work_q[j].rank < work_q[k].rank) begin
					rr_row[k].rank = rr_row[k].rank + 1'b1;
				end
			end
			if (work_q[k].v) begin
				rr_cnt = rr_cnt + 1'b1;
				if (!rr_hit && work_q[k].addr == mac_q) begin
					rr_hit     = 1'b1;
					rr_hit_idx = MAC_W'(k);
				end
			end
		end
	end

	// refresh, or evict oldest when full and insert as newest
	always_comb begin
		up_row     = work_q;
		up_full    = (cnt_q == CNT_W'(MACS_PER_IP));
		up_repl    = !hit_q && up_full;
		up_cnt     = cnt_q;
		free_found = 1'b0;
		if (hit_q) begin
			up_row[hit_idx_q].stamp = now_q;
		end else begin
			if (!up_full) begin
				up_cnt = cnt_q + 1'b1;
			end
			for (int k = 0; k < MACS_PER_IP; k++) begin
				if (up_full && up_row[k].v && up_row[k].rank == MAC_W'(MACS_PER_IP - 1)) begin
					up_row[k].v = 1'b0;
				end
			end
			for (int k = 0; k < MACS_PER_IP; k++) begin
				if (up_row[k].v) begin
					up_row[k].rank = up_row[k].rank + 1'b1;
				end else if (!free_found) begin
					free_found      = 1'b1;
					up_row[k].v     = 1'b1;
					up_row[k].addr  = mac_q;
					up_row[k].stamp = now_q;
					up_row[k].rank  = '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.expire) begin
			work_q <= ex_row;
		end else if (cmd.rerank) begin
			work_q    <= rr_row;
			hit_q     <= rr_hit;
			hit_idx_q <= rr_hit_idx;
			cnt_q     <= rr_cnt;
		end else if (cmd.update) begin
			work_q <= up_row;
			cnt_q  <= up_cnt;
			repl_q <= up_repl;
		end
		if (cmd.write_back) begin
			emit_r_q <= '0;
		end else if (cmd.emit == EM_ALERT) begin
			emit_r_q <= emit_r_q + 1'b1;
		end
	end

	// pick the slot holding the current rank
	always_comb begin
		sel_mac = '0;
		for (int k = 0; k < MACS_PER_IP; k++) begin
			if (work_q[k].v && work_q[k].rank == emit_r_q[MAC_W-1:0]) begin
				sel_mac = work_q[k].addr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.emit != EM_NONE);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.emit)
			EM_IGNORE: begin
				res_q.status       <= ST_IGNORED;
				res_q.ip_echo      <= '0;
				res_q.listed_mac   <= '0;
				res_q.mac_count    <= '0;
				res_q.mac_replaced <= 1'b0;
				res_q.last         <= 1'b1;
			end
			EM_FULL: begin
				res_q.status       <= ST_FULL;
				res_q.ip_echo      <= ip_q;
				res_q.listed_mac   <= mac_q;
				res_q.mac_count    <= '0;
				res_q.mac_replaced <= 1'b0;
				res_q.last         <= 1'b1;
			end
			EM_INFO: begin
				res_q.status       <= ST_INFO;
				res_q.ip_echo      <= ip_q;
				res_q.listed_mac   <= mac_q;
				res_q.mac_count    <= 4'(cnt_q);
				res_q.mac_replaced <= repl_q;
				res_q.last         <= 1'b1;
			end
			EM_ALERT: begin
				res_q.status       <= ST_ALERT;
				res_q.ip_echo      <= ip_q;
				res_q.listed_mac   <= sel_mac;
				res_q.mac_count    <= 4'(cnt_q);
				res_q.mac_replaced <= repl_q;
				res_q.last         <= st.run_last;
			end
			default: res_q <= res_q;
		endcase
	end

	assign st.arp       = (item.frame_length >= MIN_ARP_FRAME) && (item.eth_proto == ETYPE_ARP);
	assign st.scan_last = (scan_cnt_q == IP_W'(IP_ENTRIES - 1));
	assign st.full      = !match_q && !inval_q && !stale_q;
	assign st.single    = (cnt_q == CNT_W'(1));
	assign st.run_last  = (emit_r_q + 1'b1 == cnt_q);

	assign result        = res_q;
	assign result_strobe = strobe_q;

endmodule

>>> rtl/core/arp_ip_mac_conflict_watch.sv
// ARP IP/MAC conflict watch, top level. Depends on aimcw_pkg, aimcw_ctrl, aimcw_dp.
// Short or non-ARP frame: result in the cycle after acceptance, busy stays low. ARP: the
// whole IP table is scanned, then a decide step; a full table result is emitted from it. Else
// row read, expiry, rerank, update and write-back update the record, then info for one MAC,
// or an alert run of n results, one a cycle. Strobed results; the receiver cannot stall.
// Reset (arst_n, async) clears the IP valid bits and sets the window to 300 s.
module arp_ip_mac_conflict_watch (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  aimcw_pkg::item_t item,
	input  logic             window_we,
	input  logic [15:0]      window_data,
	output aimcw_pkg::res_t  result,
	output logic             result_strobe
);
	import aimcw_pkg::*;

	cmd_t cmd;
	st_t  st;

	// sequencer: owns the transaction flow
	aimcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	// storage and record arithmetic
	aimcw_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.window_we     (window_we),
		.window_data   (window_data),
		.cmd           (cmd),
		.st            (st),
		.result        (result),
		.result_strobe (result_strobe)
	);

	// an ignored transaction carries nothing but last
	a_ignored_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.status == ST_IGNORED |->
			result.last && result.ip_echo == '0 && result.mac_count == '0)
		else $error("ignored result carries payload");

	// info is only ever for a single MAC
	a_info_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.status == ST_INFO |-> result.mac_count == 4'd1)
		else $error("info result with count other than one");

	// an alert run is not cut short: a non-final entry is followed by another
	a_alert_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.status == ST_ALERT && !result.last |=>
			result_strobe && result.status == ST_ALERT)
		else $error("alert run broken");

	// no new transaction is taken while a run is still being emitted
	a_busy_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.status == ST_ALERT && !result.last |-> busy)
		else $error("idle during alert run");

endmodule

>>> tb/arp_ip_mac_conflict_watch_tb.sv
// Testbench for arp_ip_mac_conflict_watch: directed and random frames checked against
// a behavioural model of the IP/MAC record table kept in this file.
// Depends on aimcw_pkg and the RTL top level only.
`timescale 1ns / 100ps

module arp_ip_mac_conflict_watch_tb;
	import aimcw_pkg::*;

	localparam int SLOTS     = IP_ENTRIES * MACS_PER_IP;
	localparam int CYC_LIMIT = 400000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    window_we;
	logic [15:0] window_data;
	res_t    result;
	logic    result_strobe;

	arp_ip_mac_conflict_watch uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.window_we(window_we), .window_data(window_data),
		.result(result), .result_strobe(result_strobe)
	);

	// shadow copy of the record table
	logic [15:0] win_shadow;
	logic        ip_v   [IP_ENTRIES];
	logic [31:0] ip_a   [IP_ENTRIES];
	logic        mac_v  [SLOTS];
	logic [47:0] mac_a  [SLOTS];
	logic [31:0] mac_t  [SLOTS];
	int          mac_r  [SLOTS];

	item_t pending_frames[$];
	res_t  expected_results[$];
	int    n_errors, n_frames, n_results, n_alerts, n_full, cycles;
	bit    idle_enable;

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic bit stale(logic [31:0] ts, logic [31:0] now);
		logic [31:0] age;
		age = now - ts;
		return age > {16'd0, win_shadow};
	endfunction

	function automatic void drop_mac(int base, int k);
		int r;
		r = mac_r[base + k];
		mac_v[base + k] = 1'b0;
		for (int j = 0; j < MACS_PER_IP; j++)
			if (mac_v[base + j] && mac_r[base + j] > r)
				mac_r[base + j]--;
	endfunction

	function automatic void push_res(status_t st, logic [31:0] ip, logic [47:0] mac,
			int cnt, bit rep, bit lst);
		res_t r;
		r.status = st;
		r.ip_echo = ip;
		r.listed_mac = mac;
		r.mac_count = cnt[3:0];
		r.mac_replaced = rep;
		r.last = lst;
		expected_results.push_back(r);
	endfunction

	// predicts the results of one accepted frame and updates the shadow table
	function automatic void track_frame(item_t f);
		int rec, base, cnt, hit, freek, old;
		bit replaced, dead;
		rec = -1;
		replaced = 0;
		if (f.frame_length < MIN_ARP_FRAME || f.eth_proto != ETYPE_ARP) begin
			push_res(ST_IGNORED, '0, '0, 0, 1'b0, 1'b1);
			return;
		end
		for (int j = 0; j < IP_ENTRIES && rec < 0; j++)
			if (ip_v[j] && ip_a[j] == f.sender_ip) rec = j;
		if (rec < 0) begin
			for (int j = 0; j < IP_ENTRIES && rec < 0; j++)
				if (!ip_v[j]) rec = j;
			for (int j = 0; j < IP_ENTRIES && rec < 0; j++) begin
				dead = 1;
				for (int k = 0; k < MACS_PER_IP; k++)
					if (mac_v[j*MACS_PER_IP + k] &&
							!stale(mac_t[j*MACS_PER_IP + k], f.now_seconds))
						dead = 0;
				if (dead) rec = j;
			end
			if (rec < 0) begin
				push_res(ST_FULL, f.sender_ip, f.sender_mac, 0, 1'b0, 1'b1);
				return;
			end
			ip_v[rec] = 1'b1;
			ip_a[rec] = f.sender_ip;
			for (int k = 0; k < MACS_PER_IP; k++) mac_v[rec*MACS_PER_IP + k] = 1'b0;
		end
		base = rec * MACS_PER_IP;
		for (int j = 0; j < MACS_PER_IP; j++)
			if (mac_v[base + j] && stale(mac_t[base + j], f.now_seconds))
				drop_mac(base, j);
		hit = -1;
		cnt = 0;
		for (int j = 0; j < MACS_PER_IP; j++)
			if (mac_v[base + j]) begin
				cnt++;
				if (hit < 0 && mac_a[base + j] == f.sender_mac) hit = j;
			end
		if (hit >= 0) mac_t[base + hit] = f.now_seconds;
		else begin
			freek = -1;
			if (cnt >= MACS_PER_IP) begin
				old = 0;
				for (int j = 1; j < MACS_PER_IP; j++)
					if (mac_r[base + j] > mac_r[base + old]) old = j;
				drop_mac(base, old);
				replaced = 1;
			end
			for (int j = 0; j < MACS_PER_IP; j++)
				if (mac_v[base + j]) mac_r[base + j]++;
				else if (freek < 0) freek = j;
			mac_v[base + freek] = 1'b1;
			mac_a[base + freek] = f.sender_mac;
			mac_t[base + freek] = f.now_seconds;
			mac_r[base + freek] = 0;
		end
		cnt = 0;
		for (int j = 0; j < MACS_PER_IP; j++) if (mac_v[base + j]) cnt++;
		if (cnt <= 1) begin
			push_res(ST_INFO, f.sender_ip, f.sender_mac, cnt, replaced, 1'b1);
			return;
		end
		for (int r = 0; r < cnt; r++)
			for (int j = 0; j < MACS_PER_IP; j++)
				if (mac_v[base + j] && mac_r[base + j] == r) begin
					push_res(ST_ALERT, f.sender_ip, mac_a[base + j], cnt, replaced,
						r + 1 == cnt);
					break;
				end
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_results);
		n_errors++;
	endtask

	// driver: presents frames at the falling edge; a frame counts as taken once the
	// acceptance block has logged it at the rising edge
	int gap;
	int n_offered;
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			gap = 0;
		end else if (!start || n_frames == n_offered) begin
			if (gap > 0) begin
				gap--;
				start <= 1'b0;
			end else if (pending_frames.size() > 0 && idle_enable &&
					$urandom_range(0, 5) == 0) begin
				gap = $urandom_range(0, 6);
				start <= 1'b0;
			end else if (pending_frames.size() > 0) begin
				item <= pending_frames.pop_front();
				start <= 1'b1;
				n_offered++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// acceptance seen at the rising edge
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			track_frame(item);
			n_frames++;
		end
	end

	// monitor: every strobed result is compared with the oldest expectation
	always @(posedge clk) begin
		res_t w;
		cycles++;
		if (arst_n && result_strobe) begin
			n_results++;
			if (expected_results.size() == 0)
				report_mismatch("unexpected transaction", 64'(result), 64'd0);
			else begin
				w = expected_results.pop_front();
				if (result.status != w.status)
					report_mismatch("status", 64'(result.status), 64'(w.status));
				if (result.ip_echo != w.ip_echo)
					report_mismatch("ip_echo", 64'(result.ip_echo), 64'(w.ip_echo));
				if (result.listed_mac != w.listed_mac)
					report_mismatch("listed_mac", 64'(result.listed_mac),
						64'(w.listed_mac));
				if (result.mac_count != w.mac_count)
					report_mismatch("mac_count", 64'(result.mac_count),
						64'(w.mac_count));
				if (result.mac_replaced != w.mac_replaced)
					report_mismatch("mac_replaced", 64'(result.mac_replaced),
						64'(w.mac_replaced));
				if (result.last != w.last)
					report_mismatch("last", 64'(result.last), 64'(w.last));
				if (w.status == ST_ALERT && w.last) n_alerts++;
				if (w.status == ST_FULL) n_full++;
			end
		end
		if (cycles > CYC_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic item_t arp_frame(logic [31:0] ip, logic [47:0] mac,
			logic [31:0] now);
		item_t f;
		f.frame_length = 16'(MIN_ARP_FRAME + $urandom_range(0, 40));
		f.eth_proto = ETYPE_ARP;
		f.sender_ip = ip;
		f.sender_mac = mac;
		f.now_seconds = now;
		return f;
	endfunction

	// waits until the queues drain, then lets the block settle
	task automatic drain();
		wait (pending_frames.size() == 0 && !start && expected_results.size() == 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_window(logic [15:0] w);
		@(negedge clk);
		window_we <= 1'b1;
		window_data <= w;
		@(negedge clk);
		window_we <= 1'b0;
		win_shadow = w;
	endtask

	initial begin
		logic [31:0] t;
		logic [31:0] ips[16];
		item_t f;
		int burst;
		arst_n = 1'b0;
		window_we = 1'b0;
		window_data = '0;
		idle_enable = 1;
		win_shadow = WINDOW_RESET;
		for (int j = 0; j < IP_ENTRIES; j++) ip_v[j] = 0;
		for (int j = 0; j < SLOTS; j++) begin
			mac_v[j] = 0; mac_r[j] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: ignored frames at the field extremes
		f = '0;
		pending_frames.push_back(f);
		f = '1;
		pending_frames.push_back(f);
		f = arp_frame(32'hFFFF_FFFF, '1, '1);
		f.frame_length = MIN_ARP_FRAME - 1;
		pending_frames.push_back(f);
		f.eth_proto = 16'h0800;
		f.frame_length = 16'hFFFF;
		pending_frames.push_back(f);
		// info, then refresh, then alert run growing past a full MAC list
		t = 32'd1000;
		pending_frames.push_back(arp_frame(32'h0, 48'h0, t));
		pending_frames.push_back(arp_frame(32'h0, 48'h0, t + 300));
		for (int k = 1; k <= MACS_PER_IP + 2; k++)
			pending_frames.push_back(arp_frame(32'h0, 48'(k) | 48'hFFFF_0000_0000, t + 300));
		// everything older than the window drops out, across time wrap-around
		pending_frames.push_back(arp_frame(32'h0, 48'h5, t + 601));
		pending_frames.push_back(arp_frame(32'hFFFF_FFFF, '1, 32'hFFFF_FFF0));
		pending_frames.push_back(arp_frame(32'hFFFF_FFFF, 48'h1, 32'h10));
		drain();

		// window of zero: only sightings in the same second survive
		set_window(16'd0);
		for (int k = 0; k < 6; k++)
			pending_frames.push_back(arp_frame(32'hA, 48'(k), 32'd5000 + (k / 3)));
		drain();

		// fill the IP table, then overflow it, then reuse an expired record
		set_window(16'hFFFF);
		t = 32'd100000;
		for (int j = 0; j < IP_ENTRIES + 4; j++)
			pending_frames.push_back(arp_frame(32'h0A00_0000 + j, 48'(j), t));
		pending_frames.push_back(arp_frame(32'h0B00_0000, 48'h1, t + 32'h1_0000));
		drain();

		// random: a small pool of IPs so that records collide and fill
		set_window(16'd50);
		for (int j = 0; j < 16; j++) ips[j] = $urandom;
		t = $urandom;
		for (int n = 0; n < 240; n++) begin
			if (n == 80) begin
				drain(); set_window(16'($urandom_range(1, 400)));
			end
			if (n == 160) begin
				drain(); set_window(WINDOW_RESET); idle_enable = 0;
			end
			t += $urandom_range(0, 20);
			if ($urandom_range(0, 9) == 0) begin
				f.frame_length = 16'($urandom);
				f.eth_proto = ($urandom_range(0, 1)) ? ETYPE_ARP : 16'($urandom);
				f.sender_ip = $urandom;
				f.sender_mac = {16'($urandom), 32'($urandom)};
				f.now_seconds = $urandom;
			end else begin
				burst = $urandom_range(0, 11);
				f = arp_frame(ips[$urandom_range(0, 15)],
					{16'($urandom), 28'd0, 4'(burst)}, t);
				if ($urandom_range(0, 3) == 0) f.sender_mac[47:32] = 16'h0;
			end
			pending_frames.push_back(f);
		end
		drain();

		$display("covered %0d frames, %0d results, %0d alert runs, %0d table-full",
			n_frames, n_results, n_alerts, n_full);
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> files.f
rtl/core/aimcw_pkg.sv
rtl/core/aimcw_ctrl.sv
rtl/core/aimcw_dp.sv
rtl/core/arp_ip_mac_conflict_watch.sv
tb/arp_ip_mac_conflict_watch_tb.sv
